[hdl/bts_pkg.sv]
// Shared types and constants for the bilinear texture sampler.
// Used by every module of the block; depends on nothing.
package bts_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_DIM_DEF      = 256;
   localparam int COORD_FRAC_DEF   = 16;
   localparam int CHANNEL_BITS_DEF = 16;

   // Fixed port widths.
   localparam int COORD_W     = 24;
   localparam int CHAN_W      = 16;
   localparam int POS_W       = 8;
   localparam int MODE_W      = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 3;

   // Result queue depth; must exceed the pipeline latency for full rate.
   localparam int QUEUE_DEPTH = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEX_WIDTH,
      CSR_TEX_HEIGHT,
      CSR_U_MODE,
      CSR_V_MODE,
      CSR_TEX_VALID
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      ADDR_WRAP,
      ADDR_MIRROR,
      ADDR_CLAMP
   } addr_mode_type;

   typedef enum logic {
      KIND_LOAD,
      KIND_SAMPLE
   } item_kind_type;

   localparam logic [CSR_DATA_W-1:0] SIZE_RESET = 9'd256;

   // Control bits that travel with an item down the pipeline.
   typedef struct packed {
      logic valid;
      logic sample;
      logic white;
   } stage_ctl_type;

   // One filtered result item.
   typedef struct packed {
      logic [CHAN_W-1:0] opacity;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgba_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[hdl/bts_coord.sv]
// One axis of coordinate handling: address mode (wrap, mirror, clamp) and
// scaling by the texture size minus one. Purely combinational; uses bts_pkg.
module bts_coord
   import bts_pkg::*;
#(
   parameter int FRAC_BITS = COORD_FRAC_DEF,
   parameter int SIZE_W    = 8
) (
   input  logic [COORD_W-1:0]          coord,
   input  logic [MODE_W-1:0]           mode,
   input  logic [SIZE_W-1:0]           size_m1,
   output logic [FRAC_BITS+SIZE_W:0]   scaled
);

   localparam int EXT_W = (FRAC_BITS + 2 > COORD_W) ? FRAC_BITS + 2 : COORD_W;
   localparam int A_W   = FRAC_BITS + 1;
   localparam int S_W   = FRAC_BITS + SIZE_W + 1;
   localparam logic [A_W-1:0] ONE     = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [A_W:0]   TWO_ONE = {2'b10, {FRAC_BITS{1'b0}}};

   logic [EXT_W-1:0] ext;
   logic             neg;
   logic [A_W-1:0]   period;
   logic [A_W-1:0]   addr;

   // Sign-extend so that a period of two stays intact for wide fractions.
   assign ext    = EXT_W'($signed(coord));
   assign neg    = coord[COORD_W-1];
   assign period = ext[FRAC_BITS:0];

   // Fold the coordinate into 0..1 according to the address mode.
   always_comb begin
      unique case (mode)
         ADDR_WRAP: begin
            addr = {1'b0, ext[FRAC_BITS-1:0]};
         end
         ADDR_MIRROR: begin
            if (period <= ONE) begin
               addr = period;
            end else begin
               addr = A_W'(TWO_ONE - {1'b0, period});
            end
         end
         default: begin
            // Clamp, and the unused mode code behaves the same way.
            if (neg) begin
               addr = '0;
            end else if (ext > EXT_W'(ONE)) begin
               addr = ONE;
            end else begin
               addr = period;
            end
         end
      endcase
   end

   // Scale to texel units; integer part above FRAC_BITS, fraction below.
   assign scaled = S_W'(addr) * S_W'(size_m1);

endmodule

[hdl/bts_texmem.sv]
// Texel store split into four banks by column and row parity, so that the
// four neighbours of a sample are read together. Uses bts_pkg.
module bts_texmem
   import bts_pkg::*;
#(
   parameter int FRAC_BITS = COORD_FRAC_DEF,
   parameter int SIZE_W    = 8,
   parameter int CHAN_BITS = CHANNEL_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  stage_ctl_type               ctl_a,
   input  logic [FRAC_BITS+SIZE_W:0]   scaled_x,
   input  logic [FRAC_BITS+SIZE_W:0]   scaled_y,
   input  logic [SIZE_W-1:0]           width_m1,
   input  logic [SIZE_W-1:0]           height_m1,
   input  logic                        ld_en,
   input  logic [SIZE_W-1:0]           ld_x,
   input  logic [SIZE_W-1:0]           ld_y,
   input  logic [4*CHAN_BITS-1:0]      ld_texel,
   output stage_ctl_type               ctl_b,
   output logic [FRAC_BITS-1:0]        frac_x,
   output logic [FRAC_BITS-1:0]        frac_y,
   output logic [4*CHAN_BITS-1:0]      t00,
   output logic [4*CHAN_BITS-1:0]      t10,
   output logic [4*CHAN_BITS-1:0]      t01,
   output logic [4*CHAN_BITS-1:0]      t11
);

   localparam int HALF_W     = (SIZE_W > 1) ? SIZE_W - 1 : 1;
   localparam int ADDR_W     = 2 * HALF_W;
   localparam int BANK_DEPTH = 1 << ADDR_W;
   localparam int TEXEL_W    = 4 * CHAN_BITS;

   logic [SIZE_W-1:0]    x0, x1, y0, y1;
   logic [TEXEL_W-1:0]   bank_q [4];
   logic                 load_we;
   logic [ADDR_W-1:0]    load_addr;

   stage_ctl_type        ctl_b_ff;
   logic [FRAC_BITS-1:0] frac_x_ff, frac_y_ff;
   logic                 x0p_ff, x1p_ff, y0p_ff, y1p_ff;

   function automatic logic [HALF_W-1:0] half_pos(input logic [SIZE_W-1:0] v);
      return HALF_W'(v >> 1);
   endfunction

   function automatic logic [TEXEL_W-1:0] pick(input logic [1:0] sel,
                                               input logic [TEXEL_W-1:0] d0,
                                               input logic [TEXEL_W-1:0] d1,
                                               input logic [TEXEL_W-1:0] d2,
                                               input logic [TEXEL_W-1:0] d3);
      logic [TEXEL_W-1:0] r;
      unique case (sel)
         2'd0:    r = d0;
         2'd1:    r = d1;
         2'd2:    r = d2;
         default: r = d3;
      endcase
      return r;
   endfunction

   // Floor texel and its neighbour, held at the far edge.
   assign x0 = scaled_x[FRAC_BITS +: SIZE_W];
   assign y0 = scaled_y[FRAC_BITS +: SIZE_W];
   assign x1 = (x0 == width_m1)  ? x0 : SIZE_W'(x0 + 1'b1);
   assign y1 = (y0 == height_m1) ? y0 : SIZE_W'(y0 + 1'b1);

   // A load writes in the same stage where a sample reads, so a later
   // sample always sees every earlier load.
   assign load_we   = ctl_a.valid && !ctl_a.sample && ld_en;
   assign load_addr = {half_pos(ld_y), half_pos(ld_x)};

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic PX = 1'(b & 1);
      localparam logic PY = 1'((b >> 1) & 1);

      logic [TEXEL_W-1:0] mem [BANK_DEPTH];
      logic [TEXEL_W-1:0] rd_ff;
      logic [SIZE_W-1:0]  xs, ys;
      logic [ADDR_W-1:0]  rd_addr;
      logic               we;

      // Each bank serves whichever neighbour has its parity.
      assign xs      = (x0[0] == PX) ? x0 : x1;
      assign ys      = (y0[0] == PY) ? y0 : y1;
      assign rd_addr = {half_pos(ys), half_pos(xs)};
      assign we      = load_we && (ld_x[0] == PX) && (ld_y[0] == PY);

      always_ff @(posedge clock) begin
         if (we) begin
            mem[load_addr] <= ld_texel;
         end
         rd_ff <= mem[rd_addr];
      end

      assign bank_q[b] = rd_ff;
   end

   // Pipeline registers alongside the bank reads.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else begin
         ctl_b_ff <= ctl_a;
      end
      frac_x_ff <= scaled_x[FRAC_BITS-1:0];
      frac_y_ff <= scaled_y[FRAC_BITS-1:0];
      x0p_ff    <= x0[0];
      x1p_ff    <= x1[0];
      y0p_ff    <= y0[0];
      y1p_ff    <= y1[0];
   end

   // Route bank outputs back to neighbour positions.
   assign t00 = pick({y0p_ff, x0p_ff}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
   assign t10 = pick({y0p_ff, x1p_ff}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
   assign t01 = pick({y1p_ff, x0p_ff}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);
   assign t11 = pick({y1p_ff, x1p_ff}, bank_q[0], bank_q[1], bank_q[2], bank_q[3]);

   assign ctl_b  = ctl_b_ff;
   assign frac_x = frac_x_ff;
   assign frac_y = frac_y_ff;

endmodule

[hdl/bts_filter.sv]
// Bilinear blend of four texels per channel: a horizontal lerp stage and a
// vertical lerp stage, each with round-half-up. Uses bts_pkg.
module bts_filter
   import bts_pkg::*;
#(
   parameter int FRAC_BITS = COORD_FRAC_DEF,
   parameter int CHAN_BITS = CHANNEL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  stage_ctl_type             ctl_b,
   input  logic [FRAC_BITS-1:0]      frac_x,
   input  logic [FRAC_BITS-1:0]      frac_y,
   input  logic [4*CHAN_BITS-1:0]    t00,
   input  logic [4*CHAN_BITS-1:0]    t10,
   input  logic [4*CHAN_BITS-1:0]    t01,
   input  logic [4*CHAN_BITS-1:0]    t11,
   output logic                      push,
   output rgba_type                  result
);

   localparam int LERP_W = CHAN_BITS + FRAC_BITS + 2;
   localparam logic signed [LERP_W-1:0] HALF = LERP_W'(1) << (FRAC_BITS - 1);
   localparam logic [CHAN_BITS-1:0] WHITE = {CHAN_BITS{1'b1}};

   stage_ctl_type        ctl_c_ff;
   logic [FRAC_BITS-1:0] frac_y_ff;
   logic [CHAN_BITS-1:0] row0_in [4];
   logic [CHAN_BITS-1:0] row1_in [4];
   logic [CHAN_BITS-1:0] row0_ff [4];
   logic [CHAN_BITS-1:0] row1_ff [4];
   logic [CHAN_BITS-1:0] blend [4];

   // p + (q - p) * t, rounded; the result always lies between p and q.
   function automatic logic [CHAN_BITS-1:0] lerp(input logic [CHAN_BITS-1:0] p,
                                                input logic [CHAN_BITS-1:0] q,
                                                input logic [FRAC_BITS-1:0] t);
      logic signed [CHAN_BITS:0]  d;
      logic signed [LERP_W-1:0]   prod;
      logic signed [LERP_W-1:0]   acc;
      d    = $signed({1'b0, q}) - $signed({1'b0, p});
      prod = LERP_W'(d) * LERP_W'($signed({1'b0, t}));
      acc  = $signed({2'b00, p, {FRAC_BITS{1'b0}}}) + prod + HALF;
      return acc[FRAC_BITS +: CHAN_BITS];
   endfunction

   // Horizontal blend of both rows, every channel in parallel.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         row0_in[k] = lerp(t00[k*CHAN_BITS +: CHAN_BITS], t10[k*CHAN_BITS +: CHAN_BITS],
                           frac_x);
         row1_in[k] = lerp(t01[k*CHAN_BITS +: CHAN_BITS], t11[k*CHAN_BITS +: CHAN_BITS],
                           frac_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_c_ff <= '0;
      end else begin
         ctl_c_ff <= ctl_b;
      end
      frac_y_ff <= frac_y;
      row0_ff   <= row0_in;
      row1_ff   <= row1_in;
   end

   // Vertical blend; an invalid texture gives white.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         blend[k] = ctl_c_ff.white ? WHITE : lerp(row0_ff[k], row1_ff[k], frac_y_ff);
      end
   end

   assign result.red     = CHAN_W'(blend[0]);
   assign result.green   = CHAN_W'(blend[1]);
   assign result.blue    = CHAN_W'(blend[2]);
   assign result.opacity = CHAN_W'(blend[3]);
   assign push           = ctl_c_ff.valid && ctl_c_ff.sample;

endmodule

[hdl/bts_rsp_queue.sv]
// Result queue between the filter pipeline and the response channel.
// Uses bts_pkg for the depth and the item type.
module bts_rsp_queue
   import bts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rgba_type         push_data,
   input  logic             pop,
   output rgba_type         head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rgba_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CNT_W'(count_ff + CNT_W'(push) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

[hdl/bilinear_texture_sampler.sv]
// Top level of the bilinear texture sampler: configuration registers, input
// stage, texel store, filter pipeline and result queue. Uses bts_pkg.
//
// Usage: the req channel carries load items (kind 0), which write one RGBA
// texel, and sample items (kind 1), which return one filtered texel on the
// rsp channel. Loads produce no result item. The csr port writes the texture
// size, the two address modes and the texture valid flag; write it only while
// no item is in flight.
// Throughput is one item per cycle while req ready is high. The four neighbour
// texels come from four banks selected by column and row parity, so each
// sample needs one read per bank. A sample's result passes through coordinate
// scaling, bank read, horizontal blend and vertical blend into the result
// queue. A load is visible to every sample accepted after it.
// When the receiver stalls, results collect in an eight-entry queue, and req
// ready drops once eight samples are accepted and not yet taken; the
// pipeline itself never stops.
// Reset clears the pipeline, the queue and the registers (size 256, clamp
// addressing, texture invalid). The texel store is not cleared; sample only
// texels that have been loaded.
module bilinear_texture_sampler
   import bts_pkg::*;
#(
   parameter int MAX_DIM         = MAX_DIM_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
   parameter int CHANNEL_BITS    = CHANNEL_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_kind,
   input  logic [POS_W-1:0]        req_texel_x,
   input  logic [POS_W-1:0]        req_texel_y,
   input  logic [CHAN_W-1:0]       req_in_red,
   input  logic [CHAN_W-1:0]       req_in_green,
   input  logic [CHAN_W-1:0]       req_in_blue,
   input  logic [CHAN_W-1:0]       req_in_opacity,
   input  logic [COORD_W-1:0]      req_coord_u,
   input  logic [COORD_W-1:0]      req_coord_v,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [CHAN_W-1:0]       rsp_out_red,
   output logic [CHAN_W-1:0]       rsp_out_green,
   output logic [CHAN_W-1:0]       rsp_out_blue,
   output logic [CHAN_W-1:0]       rsp_out_opacity,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SIZE_W   = $clog2(MAX_DIM);
   localparam int SCALED_W = COORD_FRAC_BITS + SIZE_W + 1;
   localparam int TEXEL_W  = 4 * CHANNEL_BITS;
   localparam int OCC_W    = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers; sizes are kept as saturated size minus one.
   logic [SIZE_W-1:0]    width_m1_ff, height_m1_ff;
   logic [MODE_W-1:0]    u_mode_ff, v_mode_ff;
   logic                 tex_valid_ff;

   // Input stage.
   logic                 accept;
   logic                 pop;
   stage_ctl_type        ctl_a_in, ctl_a_ff;
   logic [SCALED_W-1:0]  scaled_x_in, scaled_y_in;
   logic [SCALED_W-1:0]  scaled_x_ff, scaled_y_ff;
   logic                 ld_en_in, ld_en_ff;
   logic [SIZE_W-1:0]    ld_x_ff, ld_y_ff;
   logic [TEXEL_W-1:0]   ld_texel_in, ld_texel_ff;
   logic [OCC_W-1:0]     occ_ff, occ_in;

   // Between the pipeline parts.
   stage_ctl_type          ctl_b;
   logic [COORD_FRAC_BITS-1:0] frac_x, frac_y;
   logic [TEXEL_W-1:0]     t00, t10, t01, t11;
   logic                   push;
   rgba_type               push_data;
   rgba_type               head;
   queue_status_type       q_status;

   function automatic logic [SIZE_W-1:0] size_m1(input logic [CSR_DATA_W-1:0] s);
      logic [SIZE_W-1:0] r;
      if (s == '0) begin
         r = '0;
      end else if (int'(s) > MAX_DIM) begin
         r = SIZE_W'(MAX_DIM - 1);
      end else begin
         r = SIZE_W'(s - 1'b1);
      end
      return r;
   endfunction

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff  <= size_m1(SIZE_RESET);
         height_m1_ff <= size_m1(SIZE_RESET);
         u_mode_ff    <= ADDR_CLAMP;
         v_mode_ff    <= ADDR_CLAMP;
         tex_valid_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:  width_m1_ff  <= size_m1(csr_wdata);
            CSR_TEX_HEIGHT: height_m1_ff <= size_m1(csr_wdata);
            CSR_U_MODE:     u_mode_ff    <= csr_wdata[MODE_W-1:0];
            CSR_V_MODE:     v_mode_ff    <= csr_wdata[MODE_W-1:0];
            CSR_TEX_VALID:  tex_valid_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Accept while the queue can hold every sample in flight.
   assign req_ready = (occ_ff < OCC_W'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      occ_in = occ_ff;
      if (accept && (req_kind == KIND_SAMPLE)) begin
         occ_in = OCC_W'(occ_in + 1'b1);
      end
      if (pop) begin
         occ_in = OCC_W'(occ_in - 1'b1);
      end
   end

   // Coordinate address mode and scaling for both axes.
   bts_coord #(
      .FRAC_BITS (COORD_FRAC_BITS),
      .SIZE_W    (SIZE_W)
   ) u_coord_x (
      .coord   (req_coord_u),
      .mode    (u_mode_ff),
      .size_m1 (width_m1_ff),
      .scaled  (scaled_x_in)
   );

   bts_coord #(
      .FRAC_BITS (COORD_FRAC_BITS),
      .SIZE_W    (SIZE_W)
   ) u_coord_y (
      .coord   (req_coord_v),
      .mode    (v_mode_ff),
      .size_m1 (height_m1_ff),
      .scaled  (scaled_y_in)
   );

   // Loads outside the store are dropped; extra channel bits are cut.
   assign ld_en_in    = (int'(req_texel_x) < MAX_DIM) && (int'(req_texel_y) < MAX_DIM);
   assign ld_texel_in = {CHANNEL_BITS'(req_in_opacity), CHANNEL_BITS'(req_in_blue),
                         CHANNEL_BITS'(req_in_green), CHANNEL_BITS'(req_in_red)};

   always_comb begin
      ctl_a_in.valid  = accept;
      ctl_a_in.sample = (req_kind == KIND_SAMPLE);
      ctl_a_in.white  = !tex_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         occ_ff   <= '0;
      end else begin
         ctl_a_ff <= ctl_a_in;
         occ_ff   <= occ_in;
      end
      scaled_x_ff <= scaled_x_in;
      scaled_y_ff <= scaled_y_in;
      ld_en_ff    <= ld_en_in;
      ld_x_ff     <= SIZE_W'(req_texel_x);
      ld_y_ff     <= SIZE_W'(req_texel_y);
      ld_texel_ff <= ld_texel_in;
   end

   bts_texmem #(
      .FRAC_BITS (COORD_FRAC_BITS),
      .SIZE_W    (SIZE_W),
      .CHAN_BITS (CHANNEL_BITS)
   ) u_texmem (
      .clock     (clock),
      .reset     (reset),
      .ctl_a     (ctl_a_ff),
      .scaled_x  (scaled_x_ff),
      .scaled_y  (scaled_y_ff),
      .width_m1  (width_m1_ff),
      .height_m1 (height_m1_ff),
      .ld_en     (ld_en_ff),
      .ld_x      (ld_x_ff),
      .ld_y      (ld_y_ff),
      .ld_texel  (ld_texel_ff),
      .ctl_b     (ctl_b),
      .frac_x    (frac_x),
      .frac_y    (frac_y),
      .t00       (t00),
      .t10       (t10),
      .t01       (t01),
      .t11       (t11)
   );

   bts_filter #(
      .FRAC_BITS (COORD_FRAC_BITS),
      .CHAN_BITS (CHANNEL_BITS)
   ) u_filter (
      .clock  (clock),
      .reset  (reset),
      .ctl_b  (ctl_b),
      .frac_x (frac_x),
      .frac_y (frac_y),
      .t00    (t00),
      .t10    (t10),
      .t01    (t01),
      .t11    (t11),
      .push   (push),
      .result (push_data)
   );

   bts_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   assign rsp_valid       = !q_status.empty;
   assign rsp_out_red     = head.red;
   assign rsp_out_green   = head.green;
   assign rsp_out_blue    = head.blue;
   assign rsp_out_opacity = head.opacity;

   // The in-flight count never passes the queue depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("in-flight sample count exceeds queue depth");

   // The filter never delivers an item into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_status.full || pop))
      else $error("result pushed into a full queue");

   // A result waiting in the queue is always counted as in flight.
   a_rsp_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (occ_ff != '0))
      else $error("result present with no sample in flight");

   // A load item never raises the in-flight count.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_LOAD) && !pop) |=> (occ_ff == $past(occ_ff)))
      else $error("load item counted as a result");

endmodule
